// File: rtl/core/jbpg_pkg.sv
// Shared types and constants for the jitter buffer playout gate.
// Used by jbpg_ctrl, jbpg_dp and the top level; depends on nothing.
package jbpg_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_LATENCY  = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_PAUSED   = 2'd2;

  localparam logic [10:0] LAT_RESET = 11'd200;
  localparam logic [10:0] LAT_MAX   = 11'd2000;
  localparam logic [8:0]  CAP_RESET = 9'd256;
  localparam logic [8:0]  CAP_MIN   = 9'd8;

  // averaging weights in Q0.16: alpha and one minus alpha
  localparam logic [15:0] ALPHA_Q16 = 16'd6554;
  localparam logic [15:0] KEEP_Q16  = 16'd58982;
  localparam logic [56:0] ROUND_Q16 = 57'd32768;

  // half a millisecond in UQ32.8 microseconds, for rounding the pacing delay
  localparam logic [40:0] HALF_MS_Q8 = 41'd128000;

  // 256000 = 2^11 * 125: drop 11 bits, multiply by ceil(2^37 / 125) and keep
  // the bits from 37 up; exact for any 30-bit operand
  localparam logic [30:0] PACE_RECIP = 31'd1099511628;

  // the clamped target in ms times 125, shifted by 12, gives twice that target times 256000
  localparam logic [6:0]  MS_Q8_ODD  = 7'd125;

  localparam int DIV_STEPS = 41;

  // datapath commands, one cycle each
  typedef struct packed {
    logic load;        // capture the input word
    logic record_time; // last arrival <= now, seen <= 1
    logic store_gap;   // average <= gap as it is
    logic start_mul;   // begin the weighted average update
    logic finish_mul;  // average <= rounded product sum
    logic start_len;   // begin the desired length division
    logic take_len;    // latch the saturated desired length
    logic start_pace;  // begin the pacing reciprocal multiply
    logic take_pace;   // latch the pacing delay
    logic present;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic is_poll;
    logic real_frame;
    logic seen;
    logic avg_zero;
    logic release_ok;
    logic mul_done;
    logic div_done;
    logic pace_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/jbpg_ctrl.sv
// Sequencer for the playout gate: walks one word through gap update,
// division and output. Depends on jbpg_pkg for cmd_t and stat_t.
module jbpg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  jbpg_pkg::stat_t st,
  output jbpg_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECIDE    = 3'd1;
  localparam logic [2:0] S_MUL       = 3'd2;
  localparam logic [2:0] S_START_DIV = 3'd3;
  localparam logic [2:0] S_DIV_LEN   = 3'd4;
  localparam logic [2:0] S_CHECK     = 3'd5;
  localparam logic [2:0] S_DIV_PACE  = 3'd6;
  localparam logic [2:0] S_OUT       = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.is_poll || !st.real_frame) begin
          cmd.start_len = 1'b1;
          state_next    = S_DIV_LEN;
        end else if (!st.seen) begin
          cmd.record_time = 1'b1;
          cmd.start_len   = 1'b1;
          state_next      = S_DIV_LEN;
        end else if (st.avg_zero) begin
          cmd.record_time = 1'b1;
          cmd.store_gap   = 1'b1;
          state_next      = S_START_DIV;
        end else begin
          cmd.record_time = 1'b1;
          cmd.start_mul   = 1'b1;
          state_next      = S_MUL;
        end
      end
      S_MUL: begin
        if (st.mul_done) begin
          cmd.finish_mul = 1'b1;
          state_next     = S_START_DIV;
        end
      end
      S_START_DIV: begin
        cmd.start_len = 1'b1;
        state_next    = S_DIV_LEN;
      end
      S_DIV_LEN: begin
        if (st.div_done) begin
          cmd.take_len = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        // a release with a nonzero average needs the pacing delay
        if (st.is_poll && st.release_ok && !st.avg_zero) begin
          cmd.start_pace = 1'b1;
          state_next     = S_DIV_PACE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV_PACE: begin
        if (st.pace_done) begin
          cmd.take_pace = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.present = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/jbpg_dp.sv
// Datapath of the playout gate: configuration, arrival state, serial
// multiplier, long divider, pacing reciprocal multiply and output register.
// Depends on jbpg_pkg.
module jbpg_dp #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [10:0]     cfg_data,
  input  logic            in_func,
  input  logic [88:0]     in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [79:0]     out_data,
  input  jbpg_pkg::cmd_t  cmd,
  output jbpg_pkg::stat_t st
);

  localparam logic [12:0] DEPTH_CAP = 13'(QUEUE_DEPTH);

  // configuration
  logic [10:0] target_latency_ms;
  logic [8:0]  queue_capacity;
  logic        paused;

  // captured word
  logic        func;
  logic [47:0] now;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [8:0]  queue_length;

  // arrival state
  logic [47:0] last_arrival;
  logic        seen_arrival;
  logic [39:0] average_gap;

  // multiplier
  logic [39:0] mul_a;
  logic [56:0] acc;
  logic [3:0]  mul_cnt;
  logic        mul_busy;
  logic        mul_done;

  // divider
  logic [40:0] div_num;
  logic [41:0] div_den;
  logic [41:0] rem;
  logic [40:0] quo;
  logic [5:0]  div_cnt;
  logic        div_busy;
  logic        div_done;

  // pacing delay
  logic [29:0] pace_y;
  logic [60:0] pace_prod;
  logic        pace_step;
  logic        pace_done;

  // per word results
  logic [8:0]  desired;
  logic [22:0] pace;

  // output register
  logic        o_release;
  logic [8:0]  o_desired;
  logic [39:0] o_avg;
  logic [22:0] o_pace;
  logic        o_counted;

  logic [47:0] gap;
  logic [39:0] gap_q8;
  logic [56:0] acc_next;
  logic [56:0] acc_round;
  logic [42:0] trial;
  logic        fits;
  logic [10:0] lat_eff;
  logic [8:0]  cap_lo;
  logic [8:0]  cap_eff;
  logic [17:0] lat_odd;
  logic [40:0] len_num;
  logic [40:0] pace_sum;
  logic [23:0] pace_q;
  logic        real_frame;
  logic        release_ok;

  always_comb begin
    gap       = now - last_arrival;
    gap_q8    = (|gap[47:32]) ? {40{1'b1}} : {gap[31:0], 8'd0};
    acc_next  = {acc[55:0], 1'b0}
              + (jbpg_pkg::ALPHA_Q16[mul_cnt] ? {17'd0, mul_a} : 57'd0)
              + (jbpg_pkg::KEEP_Q16[mul_cnt] ? {17'd0, average_gap} : 57'd0);
    acc_round = acc + jbpg_pkg::ROUND_Q16;
    trial     = {rem, div_num[40]};
    fits      = (trial >= {1'b0, div_den});
    lat_eff   = (target_latency_ms > jbpg_pkg::LAT_MAX) ? jbpg_pkg::LAT_MAX
                                                        : target_latency_ms;
    cap_lo    = (queue_capacity < jbpg_pkg::CAP_MIN) ? jbpg_pkg::CAP_MIN : queue_capacity;
    cap_eff   = ({4'd0, cap_lo} > DEPTH_CAP) ? DEPTH_CAP[8:0] : cap_lo;
    lat_odd   = 18'(lat_eff) * 18'(jbpg_pkg::MS_Q8_ODD);
    len_num   = {11'd0, lat_odd, 12'd0} + {1'b0, average_gap};
    pace_sum  = {1'b0, average_gap} + jbpg_pkg::HALF_MS_Q8;
    pace_q    = pace_prod[60:37];
    real_frame = (frame_width != 16'd0) && (frame_height != 16'd0);
    release_ok = !paused && (queue_length >= desired);
  end

  always_comb begin
    st.is_poll    = func;
    st.real_frame = real_frame;
    st.seen       = seen_arrival;
    st.avg_zero   = (average_gap == 40'd0);
    st.release_ok = release_ok;
    st.mul_done   = mul_done;
    st.div_done   = div_done;
    st.pace_done  = pace_done;
    st.out_free   = !out_valid || out_ready;
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_latency_ms <= jbpg_pkg::LAT_RESET;
      queue_capacity    <= jbpg_pkg::CAP_RESET;
      paused            <= 1'b0;
      last_arrival      <= 48'd0;
      seen_arrival      <= 1'b0;
      average_gap       <= 40'd0;
      mul_busy          <= 1'b0;
      mul_done          <= 1'b0;
      div_busy          <= 1'b0;
      div_done          <= 1'b0;
      pace_step         <= 1'b0;
      pace_done         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jbpg_pkg::CFG_LATENCY:  target_latency_ms <= cfg_data;
          jbpg_pkg::CFG_CAPACITY: queue_capacity    <= cfg_data[8:0];
          jbpg_pkg::CFG_PAUSED:   paused            <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.record_time) begin
        last_arrival <= now;
        seen_arrival <= 1'b1;
      end
      if (cmd.store_gap) begin
        average_gap <= gap_q8;
      end else if (cmd.finish_mul) begin
        average_gap <= acc_round[55:16];
      end
      mul_done <= mul_busy && (mul_cnt == 4'd0);
      if (cmd.start_mul) begin
        mul_busy <= 1'b1;
      end else if (mul_busy && mul_cnt == 4'd0) begin
        mul_busy <= 1'b0;
      end
      div_done <= div_busy && (div_cnt == 6'd0);
      if (cmd.start_len) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_cnt == 6'd0) begin
        div_busy <= 1'b0;
      end
      pace_step <= cmd.start_pace;
      pace_done <= pace_step;
      if (cmd.present) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func         <= in_func;
      now          <= in_data[47:0];
      frame_width  <= in_data[63:48];
      frame_height <= in_data[79:64];
      queue_length <= in_data[88:80];
      pace         <= 23'd0;
    end
    // constant weights scanned msb first
    if (cmd.start_mul) begin
      mul_a   <= gap_q8;
      acc     <= 57'd0;
      mul_cnt <= 4'd15;
    end else if (mul_busy) begin
      acc     <= acc_next;
      mul_cnt <= mul_cnt - 4'd1;
    end
    // restoring division, one quotient bit per cycle
    if (cmd.start_len) begin
      div_num <= len_num;
      div_den <= {1'b0, average_gap, 1'b0};
      rem     <= 42'd0;
      div_cnt <= 6'(jbpg_pkg::DIV_STEPS - 1);
    end else if (div_busy) begin
      div_num <= {div_num[39:0], 1'b0};
      rem     <= fits ? 42'(trial - {1'b0, div_den}) : trial[41:0];
      quo     <= {quo[39:0], fits};
      div_cnt <= div_cnt - 6'd1;
    end
    // rounded milliseconds: shift out 2^11, then divide by 125 by reciprocal
    if (cmd.start_pace) begin
      pace_y <= pace_sum[40:11];
    end
    if (pace_step) begin
      pace_prod <= {31'd0, pace_y} * {30'd0, jbpg_pkg::PACE_RECIP};
    end
    if (cmd.take_len) begin
      if (average_gap == 40'd0 || quo == 41'd0) begin
        desired <= 9'd1;
      end else if (quo > {32'd0, cap_eff}) begin
        desired <= cap_eff;
      end else begin
        desired <= quo[8:0];
      end
    end
    if (cmd.take_pace) begin
      pace <= (pace_q == 24'd0) ? 23'd0 : 23'(pace_q - 24'd1);
    end
    if (cmd.present) begin
      o_release <= func && release_ok;
      o_desired <= desired;
      o_avg     <= average_gap;
      o_pace    <= (func && release_ok) ? pace : 23'd0;
      o_counted <= !func && real_frame;
    end
  end

  assign out_data = {6'd0, o_counted, o_pace, o_avg, o_desired, o_release};

endmodule

// File: rtl/core/jitter_buffer_playout_gate.sv
// Channel   Handshake            Payload
// s (in)    s_tvalid / s_tready  s_tuser = func, s_tdata = arrival, size, queue length
// m (out)   m_tvalid / m_tready  m_tdata = release, desired, average, pace, counted
// cfg       cfg_we               cfg_index, cfg_data
//
// One word at a time: the next word is taken only once the result of the last one is loaded
// into the output register. Every word runs the 41-step desired-length divider; a real
// frame with a nonzero average first runs the 16-step weighted-average multiplier, and a
// releasing poll with a nonzero average then runs the pacing delay, a registered reciprocal
// multiply. rst is synchronous; it restores the register defaults and clears the arrival
// history. A stalled result waits in the output register while the next word is taken in.
module jitter_buffer_playout_gate #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // arrival_time_us[47:0], frame_width, frame_height,
                                // queue_length[8:0], zero fill
  input  logic        s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // release_res, desired_length[8:0], average_gap_q8[39:0],
                                // pace_ms[22:0], frame_counted, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  jbpg_pkg::cmd_t  cmd;
  jbpg_pkg::stat_t st;

  jbpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  jbpg_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_func   (s_tuser),
    .in_data   (s_tdata[88:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
